FILE: rtl/core/ssm_pkg.sv
package ssm_pkg;

   localparam int HoldDepthDefault = 16;
   localparam int SeqW             = 32;
   localparam int TimeW            = 48;
   localparam int HandleW          = 16;
   localparam int KindW            = 3;
   localparam int EntryW           = SeqW + KindW + HandleW;
   localparam logic [31:0] DefaultHeartbeat = 32'd30000;

   localparam logic [1:0] MODE_MSG   = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_LOGON = 2'd2;
   localparam logic [1:0] MODE_CLAIM = 2'd3;

   localparam logic [2:0] KIND_APP      = 3'd0;
   localparam logic [2:0] KIND_LOGON    = 3'd1;
   localparam logic [2:0] KIND_HEARTBT  = 3'd2;
   localparam logic [2:0] KIND_TESTREQ  = 3'd3;
   localparam logic [2:0] KIND_RESEND   = 3'd4;
   localparam logic [2:0] KIND_SEQRESET = 3'd5;
   localparam logic [2:0] KIND_LOGOUT   = 3'd6;
   localparam logic [2:0] KIND_SPARE    = 3'd7;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_PROBE  = 2'd1;
   localparam logic [1:0] ACT_REPLAY = 2'd2;
   localparam logic [1:0] ACT_RESEND = 2'd3;

   localparam logic [2:0] REJ_NONE       = 3'd0;
   localparam logic [2:0] REJ_NOT_LOGGED = 3'd1;
   localparam logic [2:0] REJ_SEQ_LOW    = 3'd2;
   localparam logic [2:0] REJ_LOGON_LOW  = 3'd3;
   localparam logic [2:0] REJ_RESET_BACK = 3'd4;
   localparam logic [2:0] REJ_DUP_LOGON  = 3'd5;
   localparam logic [2:0] REJ_QUEUE_FULL = 3'd6;

   localparam logic [2:0] PH_DISC       = 3'd0;
   localparam logic [2:0] PH_LOGON_SENT = 3'd1;
   localparam logic [2:0] PH_ACTIVE     = 3'd2;
   localparam logic [2:0] PH_RECOVER    = 3'd3;
   localparam logic [2:0] PH_LOGGED_OUT = 3'd4;

   localparam logic [1:0] CSR_INIT_IN  = 2'd0;
   localparam logic [1:0] CSR_INIT_OUT = 2'd1;
   localparam logic [1:0] CSR_HEARTBT  = 2'd2;

   typedef struct packed {
      logic              deliver;
      logic              dropped;
      logic              held;
      logic              disconnect;
      logic [1:0]        action;
      logic [SeqW-1:0]   range_start;
      logic [SeqW-1:0]   range_end;
      logic [2:0]        reject_code;
      logic [HandleW-1:0] handle_out;
      logic [SeqW-1:0]   claimed_seq;
   } result_type;

   typedef struct packed {
      logic latch;
      logic prim;
      logic ptr_clr;
      logic ptr_inc;
      logic rd_next;
      logic shift_wr;
      logic rel_latch;
      logic remove;
      logic scan_end;
      logic push;
      logic push_last;
   } cmd_type;

   typedef struct packed {
      logic rel_go;
      logic at_end;
      logic has_next;
      logic match;
      logic rel_app;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/core/ssm_ram.sv
module ssm_ram
   import ssm_pkg::*;
#(
   parameter int WIDTH = EntryW,
   parameter int DEPTH = HoldDepthDefault,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/core/ssm_ctrl.sv
module ssm_ctrl
   import ssm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_PRIM, S_SCAN, S_CHK, S_SHIFT, S_SHWR, S_REMOVE, S_FLUSH
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_PRIM;
            end
         end
         S_PRIM: begin
            cmd.prim    = 1'b1;
            cmd.ptr_clr = 1'b1;
            state_in    = status.rel_go ? S_SCAN : S_FLUSH;
         end
         S_SCAN: begin
            if (status.at_end) begin
               cmd.scan_end = 1'b1;
               state_in     = S_FLUSH;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            // entry at the pointer is on the read port now
            if (status.match) begin
               cmd.rel_latch = 1'b1;
               state_in      = S_SHIFT;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SHIFT: begin
            cmd.rd_next = 1'b1;
            state_in    = status.has_next ? S_SHWR : S_REMOVE;
         end
         S_SHWR: begin
            cmd.shift_wr = 1'b1;
            cmd.ptr_inc  = 1'b1;
            state_in     = S_SHIFT;
         end
         S_REMOVE: begin
            if (!status.rel_app || status.out_free) begin
               cmd.remove  = 1'b1;
               cmd.ptr_clr = 1'b1;
               cmd.push    = status.rel_app;
               state_in    = S_SCAN;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.push      = 1'b1;
               cmd.push_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/ssm_dp.sv
module ssm_dp
   import ssm_pkg::*;
#(
   parameter int HOLD_DEPTH = HoldDepthDefault,
   localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1,
   localparam int CW = $clog2(HOLD_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic [1:0]         req_mode,
   input  logic [KindW-1:0]   req_admin_kind,
   input  logic [SeqW-1:0]    req_msg_seq,
   input  logic [SeqW-1:0]    req_reset_target,
   input  logic               req_possible_duplicate,
   input  logic [SeqW-1:0]    req_request_from,
   input  logic [SeqW-1:0]    req_request_to,
   input  logic [TimeW-1:0]   req_now_time,
   input  logic [HandleW-1:0] req_payload_handle,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output result_type         rsp_word,
   output logic               rsp_last
);

   logic [2:0]         phase_ff;
   logic [SeqW-1:0]    exp_ff, nout_ff;
   logic [TimeW-1:0]   lht_ff;
   logic               probe_ff;
   logic [CW-1:0]      cnt_ff, ptr_ff;
   logic [31:0]        hb_ff;

   logic [1:0]         mode_ff;
   logic [KindW-1:0]   kind_ff;
   logic [SeqW-1:0]    seq_ff, tgt_ff, rf_ff, rt_ff;
   logic               pdup_ff;
   logic [TimeW-1:0]   now_ff;
   logic [HandleW-1:0] hdl_ff;

   result_type         pend_ff, out_ff;
   logic               out_last_ff, out_valid_ff;
   logic [HandleW-1:0] relh_ff;
   logic               relapp_ff;

   result_type         p_res;
   logic [2:0]         p_phase;
   logic [SeqW-1:0]    p_exp, p_nout;
   logic [TimeW-1:0]   p_lht;
   logic               p_probe, p_hold, p_rel;
   logic [31:0]        hb_eff;
   logic               up;

   logic               ram_we;
   logic [AW-1:0]      ram_wa, ram_ra;
   logic [EntryW-1:0]  ram_wd, ram_rd;
   logic [CW-1:0]      ptr_nx;
   logic               out_free;
   logic [KindW-1:0]   rd_kind;

   assign hb_eff = (hb_ff == '0) ? DefaultHeartbeat : hb_ff;
   assign up     = (phase_ff == PH_ACTIVE) || (phase_ff == PH_RECOVER);

   // primary result and state update of the latched word
   always_comb begin
      p_res   = '0;
      p_phase = phase_ff;
      p_exp   = exp_ff;
      p_nout  = nout_ff;
      p_lht   = lht_ff;
      p_probe = probe_ff;
      p_hold  = 1'b0;
      p_rel   = 1'b0;
      unique case (mode_ff)
         MODE_TICK: begin
            if ((phase_ff == PH_ACTIVE) || (phase_ff == PH_RECOVER) ||
                (phase_ff == PH_LOGON_SENT)) begin
               if ((now_ff >= lht_ff) &&
                   ((now_ff - lht_ff) >= {{(TimeW-32){1'b0}}, hb_eff})) begin
                  if (!probe_ff) begin
                     p_probe      = 1'b1;
                     p_lht        = now_ff;
                     p_res.action = ACT_PROBE;
                  end else begin
                     p_phase          = PH_DISC;
                     p_res.disconnect = 1'b1;
                  end
               end
            end
         end
         MODE_LOGON, MODE_CLAIM: begin
            if (mode_ff == MODE_LOGON) begin
               p_phase = PH_LOGON_SENT;
               p_lht   = now_ff;
               p_probe = 1'b0;
            end
            p_res.claimed_seq = nout_ff;
            p_nout            = nout_ff + 1'b1;
         end
         default: begin
            if ((phase_ff == PH_DISC) && (kind_ff != KIND_LOGON)) begin
               p_res.dropped     = 1'b1;
               p_res.reject_code = REJ_NOT_LOGGED;
            end else if ((kind_ff == KIND_LOGON) && (seq_ff < exp_ff) && !pdup_ff) begin
               p_res.dropped     = 1'b1;
               p_res.disconnect  = 1'b1;
               p_res.reject_code = REJ_LOGON_LOW;
            end else if (seq_ff < exp_ff) begin
               p_lht         = now_ff;
               p_res.dropped = 1'b1;
               if (!pdup_ff) begin
                  p_res.disconnect  = 1'b1;
                  p_res.reject_code = REJ_SEQ_LOW;
               end
            end else if ((seq_ff > exp_ff) && (kind_ff != KIND_SEQRESET)) begin
               p_lht   = now_ff;
               p_probe = 1'b0;
               if (phase_ff != PH_RECOVER) begin
                  p_phase           = PH_RECOVER;
                  p_res.action      = ACT_RESEND;
                  p_res.range_start = exp_ff;
                  p_res.range_end   = seq_ff - 1'b1;
               end
               if (cnt_ff < CW'(HOLD_DEPTH)) begin
                  p_hold     = 1'b1;
                  p_res.held = 1'b1;
               end else begin
                  p_res.dropped     = 1'b1;
                  p_res.reject_code = REJ_QUEUE_FULL;
               end
            end else begin
               p_lht   = now_ff;
               p_probe = 1'b0;
               unique case (kind_ff)
                  KIND_SEQRESET: begin
                     p_res.dropped = 1'b1;
                     if (tgt_ff <= exp_ff) begin
                        p_res.reject_code = REJ_RESET_BACK;
                     end else begin
                        p_exp = tgt_ff;
                        p_rel = 1'b1;
                     end
                  end
                  KIND_TESTREQ: begin
                     p_exp         = exp_ff + 1'b1;
                     p_res.action  = ACT_PROBE;
                     p_res.dropped = 1'b1;
                     p_rel         = 1'b1;
                  end
                  KIND_RESEND: begin
                     p_exp             = exp_ff + 1'b1;
                     p_res.action      = ACT_REPLAY;
                     p_res.range_start = rf_ff;
                     p_res.range_end   = (rt_ff == '0) ? (nout_ff - 1'b1) : rt_ff;
                     p_res.dropped     = 1'b1;
                     p_rel             = 1'b1;
                  end
                  KIND_LOGOUT: begin
                     p_exp            = exp_ff + 1'b1;
                     p_phase          = PH_LOGGED_OUT;
                     p_res.dropped    = 1'b1;
                     p_res.disconnect = 1'b1;
                     p_rel            = 1'b1;
                  end
                  KIND_HEARTBT: begin
                     p_exp         = exp_ff + 1'b1;
                     p_res.dropped = 1'b1;
                     p_rel         = 1'b1;
                  end
                  KIND_LOGON: begin
                     p_exp         = exp_ff + 1'b1;
                     p_res.dropped = 1'b1;
                     if (up) begin
                        p_res.disconnect  = 1'b1;
                        p_res.reject_code = REJ_DUP_LOGON;
                     end else begin
                        p_phase = PH_ACTIVE;
                        p_rel   = 1'b1;
                     end
                  end
                  KIND_APP, KIND_SPARE: begin
                     if (!up) begin
                        p_res.dropped     = 1'b1;
                        p_res.reject_code = REJ_NOT_LOGGED;
                     end else begin
                        p_exp            = exp_ff + 1'b1;
                        p_res.deliver    = 1'b1;
                        p_res.handle_out = hdl_ff;
                        p_rel            = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
      endcase
   end

   assign ptr_nx  = ptr_ff + 1'b1;
   assign ram_ra  = cmd.rd_next ? ptr_nx[AW-1:0] : ptr_ff[AW-1:0];
   assign ram_we  = (cmd.prim && p_hold) || cmd.shift_wr;
   assign ram_wa  = cmd.shift_wr ? ptr_ff[AW-1:0] : cnt_ff[AW-1:0];
   assign ram_wd  = cmd.shift_wr ? ram_rd : {seq_ff, kind_ff, hdl_ff};
   assign rd_kind = ram_rd[HandleW +: KindW];

   ssm_ram #(.WIDTH(EntryW), .DEPTH(HOLD_DEPTH)) u_hold (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign out_free = !out_valid_ff || !rsp_stall;

   assign status.rel_go   = p_rel && (p_phase == PH_RECOVER);
   assign status.at_end   = (ptr_ff == cnt_ff);
   assign status.has_next = (ptr_nx < cnt_ff);
   assign status.match    = (ram_rd[EntryW-1 -: SeqW] == exp_ff);
   assign status.rel_app  = relapp_ff;
   assign status.out_free = out_free;

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;
   assign rsp_last  = out_last_ff;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_mode;
         kind_ff <= req_admin_kind;
         seq_ff  <= req_msg_seq;
         tgt_ff  <= req_reset_target;
         pdup_ff <= req_possible_duplicate;
         rf_ff   <= req_request_from;
         rt_ff   <= req_request_to;
         now_ff  <= req_now_time;
         hdl_ff  <= req_payload_handle;
      end
      if (cmd.rel_latch) begin
         relh_ff   <= ram_rd[HandleW-1:0];
         relapp_ff <= (rd_kind == KIND_APP) || (rd_kind == KIND_SPARE);
      end
      if (cmd.prim) begin
         pend_ff <= p_res;
      end else if (cmd.remove && relapp_ff) begin
         pend_ff            <= '0;
         pend_ff.deliver    <= 1'b1;
         pend_ff.handle_out <= relh_ff;
      end
      if (cmd.push) begin
         out_ff      <= pend_ff;
         out_last_ff <= cmd.push_last;
      end
   end

   // session state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DISC;
         exp_ff       <= SeqW'(1);
         nout_ff      <= SeqW'(1);
         lht_ff       <= '0;
         probe_ff     <= 1'b0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         hb_ff        <= DefaultHeartbeat;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_INIT_IN:  exp_ff  <= (csr_wdata == '0) ? SeqW'(1) : csr_wdata;
               CSR_INIT_OUT: nout_ff <= (csr_wdata == '0) ? SeqW'(1) : csr_wdata;
               CSR_HEARTBT:  hb_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.prim) begin
            phase_ff <= p_phase;
            exp_ff   <= p_exp;
            nout_ff  <= p_nout;
            lht_ff   <= p_lht;
            probe_ff <= p_probe;
            if (p_hold) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (cmd.remove) begin
            cnt_ff <= cnt_ff - 1'b1;
            exp_ff <= exp_ff + 1'b1;
         end
         if (cmd.scan_end && (cnt_ff == '0)) begin
            phase_ff <= PH_ACTIVE;
         end
         if (cmd.ptr_clr) begin
            ptr_ff <= '0;
         end else if (cmd.ptr_inc) begin
            ptr_ff <= ptr_nx;
         end
         if (cmd.push) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(HOLD_DEPTH))
      else $error("hold count beyond depth");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> out_free)
      else $error("result pushed over a waiting word");

   a_remove_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("release did not shrink the hold queue");

endmodule

FILE: rtl/core/session_sequence_manager_unit.sv
// Session sequence manager: one request word gives one or more response words,
// the final one flagged by rsp_last. A tick, logon or claim word, and any
// message that does not close a recovery gap, passes through the latch,
// primary and flush states, and waits in flush while the response side stalls.
// A message that lets the hold queue drain adds a scan of the queue through its
// RAM (one write port, one read port): each entry visited takes a scan and a
// check state, and each entry moved up when one is taken out takes a shift and
// a shift-write state. Write configuration only while no request is in progress.
module session_sequence_manager_unit
   import ssm_pkg::*;
#(
   parameter int HOLD_DEPTH = HoldDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [KindW-1:0]   req_admin_kind,
   input  logic [SeqW-1:0]    req_msg_seq,
   input  logic [SeqW-1:0]    req_reset_target,
   input  logic               req_is_gap_fill,
   input  logic               req_possible_duplicate,
   input  logic [SeqW-1:0]    req_request_from,
   input  logic [SeqW-1:0]    req_request_to,
   input  logic [TimeW-1:0]   req_now_time,
   input  logic [HandleW-1:0] req_payload_handle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_deliver,
   output logic               rsp_dropped,
   output logic               rsp_held,
   output logic               rsp_disconnect,
   output logic [1:0]         rsp_action,
   output logic [SeqW-1:0]    rsp_range_start,
   output logic [SeqW-1:0]    rsp_range_end,
   output logic [2:0]         rsp_reject_code,
   output logic [HandleW-1:0] rsp_handle_out,
   output logic [SeqW-1:0]    rsp_claimed_seq,
   output logic               rsp_last
);

   cmd_type    cmd;
   status_type status;
   result_type word;
   logic       stall_raw;

   // gap fill and hard reset act alike
   assign req_stall = stall_raw | (req_is_gap_fill & 1'b0);

   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (stall_raw),
      .status    (status),
      .cmd       (cmd)
   );

   ssm_dp #(.HOLD_DEPTH(HOLD_DEPTH)) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_mode               (req_mode),
      .req_admin_kind         (req_admin_kind),
      .req_msg_seq            (req_msg_seq),
      .req_reset_target       (req_reset_target),
      .req_possible_duplicate (req_possible_duplicate),
      .req_request_from       (req_request_from),
      .req_request_to         (req_request_to),
      .req_now_time           (req_now_time),
      .req_payload_handle     (req_payload_handle),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_word               (word),
      .rsp_last               (rsp_last)
   );

   assign rsp_deliver     = word.deliver;
   assign rsp_dropped     = word.dropped;
   assign rsp_held        = word.held;
   assign rsp_disconnect  = word.disconnect;
   assign rsp_action      = word.action;
   assign rsp_range_start = word.range_start;
   assign rsp_range_end   = word.range_end;
   assign rsp_reject_code = word.reject_code;
   assign rsp_handle_out  = word.handle_out;
   assign rsp_claimed_seq = word.claimed_seq;

endmodule
